FILE: sv/cfs_pkg.sv
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared types and constants for the field splitter front end, queue and
// result sequencer.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 32;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;
    localparam logic [BYTE_W-1:0] NUL_BYTE    = 8'd0;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FIELD_DELIMITER = 1'b0,
        CFG_QUOTE_CHAR      = 1'b1
    } cfg_index_t;

    // Line status codes.
    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_EMPTY    = 1'b1;

    // One classified request as handed from the front end to the back end.
    // When two_results is set, a bare field end precedes the main result.
    typedef struct packed {
        logic                two_results;
        logic                has_byte;
        logic [BYTE_W-1:0]   data;
        logic                field_end;
        logic                line_end;
        logic                status;
        logic [COUNT_W-1:0]  line_number;
    } cfs_desc_t;

endpackage

FILE: sv/cfs_front.sv
// ----------------------------------------------------------------------------
// CSV field splitter front end
// Holds the configuration and the per-line scan state, classifies each
// request and builds the descriptor of the results it causes.
// ----------------------------------------------------------------------------
module cfs_front
    import cfs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [BYTE_W-1:0]   cfg_wdata,
    input  logic                accept,
    input  logic                in_has_byte,
    input  logic [BYTE_W-1:0]   in_data_byte,
    input  logic                in_end_of_line,
    output logic                push,
    output cfs_desc_t           desc
);

    logic [BYTE_W-1:0]  delim_reg, delim_next;
    logic [BYTE_W-1:0]  quote_reg, quote_next;
    logic               in_quote_reg, in_quote_next;
    logic               field_has_reg, field_has_next;
    logic               field_quoted_reg, field_quoted_next;
    logic               pending_reg, pending_next;
    logic               line_has_reg, line_has_next;
    logic               stopped_reg, stopped_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic is_nul, is_quote, is_delim, active;
    logic content, delim_hit, emit, quoted_now;
    logic line_has_now;
    logic [COUNT_W-1:0] count_inc;

    always_comb begin
        delim_next = delim_reg;
        quote_next = quote_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FIELD_DELIMITER: delim_next = cfg_wdata;
                CFG_QUOTE_CHAR:      quote_next = cfg_wdata;
                default:             delim_next = delim_reg;
            endcase
        end
    end

    assign is_nul       = (in_data_byte == NUL_BYTE);
    assign is_quote     = (in_data_byte == quote_reg);
    assign is_delim     = (in_data_byte == delim_reg);
    assign active       = in_has_byte && !stopped_reg;
    assign line_has_now = line_has_reg || in_has_byte;
    assign count_inc    = count_reg + COUNT_W'(1);
    assign quoted_now   = field_has_reg ? field_quoted_reg : is_quote;

    always_comb begin
        content       = 1'b0;
        delim_hit     = 1'b0;
        emit          = 1'b0;
        in_quote_next = in_quote_reg;
        stopped_next  = stopped_reg;
        pending_next  = pending_reg;
        field_has_next    = field_has_reg;
        field_quoted_next = field_quoted_reg;

        if (active) begin
            priority if (is_nul) begin
                stopped_next = 1'b1;
            end else if (in_quote_reg) begin
                // Inside quotes the delimiter is plain content; only the quote byte is tested.
                if (is_quote) in_quote_next = 1'b0;
                content = 1'b1;
            end else if (is_delim) begin
                delim_hit = 1'b1;
            end else begin
                if (is_quote) in_quote_next = 1'b1;
                content = 1'b1;
            end
        end

        if (content) begin
            field_has_next    = 1'b1;
            field_quoted_next = quoted_now;
            if (quoted_now && is_quote) begin
                // A doubled quote yields one quote, a lone one is held back.
                emit         = pending_reg;
                pending_next = !pending_reg;
            end else begin
                emit         = 1'b1;
                pending_next = 1'b0;
            end
        end

        line_has_next = line_has_now;
        count_next    = count_reg;
        if (in_end_of_line) begin
            if (line_has_now) count_next = count_inc;
            in_quote_next     = 1'b0;
            field_has_next    = 1'b0;
            field_quoted_next = 1'b0;
            pending_next      = 1'b0;
            line_has_next     = 1'b0;
            stopped_next      = 1'b0;
        end else if (delim_hit) begin
            field_has_next    = 1'b0;
            field_quoted_next = 1'b0;
            pending_next      = 1'b0;
        end
    end

    always_comb begin
        desc             = '0;
        desc.data        = in_data_byte;
        desc.status      = STATUS_ACCEPTED;
        priority if (in_end_of_line && !line_has_now) begin
            desc.line_end    = 1'b1;
            desc.status      = STATUS_EMPTY;
            desc.line_number = count_reg;
            desc.data        = '0;
        end else if (in_end_of_line) begin
            desc.two_results = delim_hit;
            desc.has_byte    = emit;
            desc.data        = emit ? in_data_byte : '0;
            desc.field_end   = 1'b1;
            desc.line_end    = 1'b1;
            desc.line_number = count_inc;
        end else if (delim_hit) begin
            desc.field_end   = 1'b1;
            desc.data        = '0;
        end else begin
            desc.has_byte    = 1'b1;
        end
    end

    assign push = accept && (in_end_of_line || delim_hit || emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg        <= DELIM_RESET;
            quote_reg        <= QUOTE_RESET;
            in_quote_reg     <= 1'b0;
            field_has_reg    <= 1'b0;
            field_quoted_reg <= 1'b0;
            pending_reg      <= 1'b0;
            line_has_reg     <= 1'b0;
            stopped_reg      <= 1'b0;
            count_reg        <= '0;
        end else begin
            delim_reg <= delim_next;
            quote_reg <= quote_next;
            if (accept) begin
                in_quote_reg     <= in_quote_next;
                field_has_reg    <= field_has_next;
                field_quoted_reg <= field_quoted_next;
                pending_reg      <= pending_next;
                line_has_reg     <= line_has_next;
                stopped_reg      <= stopped_next;
                count_reg        <= count_next;
            end
        end
    end

endmodule

FILE: sv/cfs_queue.sv
// ----------------------------------------------------------------------------
// CSV field splitter descriptor queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cfs_queue
    import cfs_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cfs_desc_t push_desc,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output cfs_desc_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cfs_desc_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slots[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/cfs_back.sv
// ----------------------------------------------------------------------------
// CSV field splitter back end
// Expands each descriptor into one or two results and drives the output
// register of the result channel.
// ----------------------------------------------------------------------------
module cfs_back
    import cfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  cfs_desc_t          q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_has_byte,
    output logic [BYTE_W-1:0]  m_byte,
    output logic               m_field_end,
    output logic               m_line_end,
    output logic               m_line_status,
    output logic [COUNT_W-1:0] m_line_number,
    output logic               m_last_of_run
);

    logic               valid_reg, valid_next;
    logic               phase_reg, phase_next;
    logic               load, lead_result;
    logic               has_byte_reg, field_end_reg, line_end_reg, status_reg, last_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [COUNT_W-1:0] number_reg;

    assign load        = q_not_empty && (!valid_reg || m_ready);
    assign lead_result = q_head.two_results && !phase_reg;
    assign q_pop       = load && !lead_result;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load) begin
            valid_next = 1'b1;
            phase_next = lead_result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (lead_result) begin
                has_byte_reg  <= 1'b0;
                byte_reg      <= '0;
                field_end_reg <= 1'b1;
                line_end_reg  <= 1'b0;
                status_reg    <= STATUS_ACCEPTED;
                number_reg    <= '0;
                last_reg      <= 1'b0;
            end else begin
                has_byte_reg  <= q_head.has_byte;
                byte_reg      <= q_head.data;
                field_end_reg <= q_head.field_end;
                line_end_reg  <= q_head.line_end;
                status_reg    <= q_head.status;
                number_reg    <= q_head.line_number;
                last_reg      <= 1'b1;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign m_has_byte    = has_byte_reg;
    assign m_byte        = byte_reg;
    assign m_field_end   = field_end_reg;
    assign m_line_end    = line_end_reg;
    assign m_line_status = status_reg;
    assign m_line_number = number_reg;
    assign m_last_of_run = last_reg;

endmodule

FILE: sv/csv_field_splitter_unit.sv
// A request's results pass through the descriptor queue, then the back end output register.
// One request per cycle unless the queue is full; a line-ending delimiter adds a result.
// The front end stalls only when the descriptor queue (QUEUE_DEPTH entries) is full.
// Reset (aresetn low, synchronous) empties the queue, clears the line and field state,
// zeroes the line count and restores the delimiter to comma and the quote to double quote.
// ----------------------------------------------------------------------------
// CSV field splitter top level
// Splits the bytes of a text line into fields at unquoted delimiters,
// unquotes fields that open with a quote and marks field and line ends.
// ----------------------------------------------------------------------------
module csv_field_splitter_unit
    import cfs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port.
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [BYTE_W-1:0]  cfg_wdata,
    // Input request channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_has_byte,
    input  logic [BYTE_W-1:0]  s_data_byte,
    input  logic               s_end_of_line,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_out_has_byte,
    output logic [BYTE_W-1:0]  m_out_byte,
    output logic               m_field_end,
    output logic               m_line_end,
    output logic               m_line_status,
    output logic [COUNT_W-1:0] m_line_number,
    output logic               m_last_of_run
);

    // The front end classifies every accepted request in the cycle it arrives
    // and updates the scan state at once, so the next byte can follow right
    // behind. Requests that cause results leave a descriptor in the queue.
    logic      accept;
    logic      q_push, q_pop, q_full, q_not_empty;
    cfs_desc_t push_desc, q_head;

    // Ready depends only on queue occupancy, never on the result channel, so
    // the two sides stall independently.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    cfs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .accept         (accept),
        .in_has_byte    (s_has_byte),
        .in_data_byte   (s_data_byte),
        .in_end_of_line (s_end_of_line),
        .push           (q_push),
        .desc           (push_desc)
    );

    // The queue decouples the scan from the result stream. When a line ends
    // on a delimiter the back end emits two results from one descriptor, and
    // the queue absorbs that.
    cfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end owns the output register and emits the bare field end
    // ahead of the final empty field when needed.
    cfs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_has_byte    (m_out_has_byte),
        .m_byte        (m_out_byte),
        .m_field_end   (m_field_end),
        .m_line_end    (m_line_end),
        .m_line_status (m_line_status),
        .m_line_number (m_line_number),
        .m_last_of_run (m_last_of_run)
    );

    // A line end carries a field end unless the line was rejected as empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_end |-> m_field_end || (m_line_status == STATUS_EMPTY))
        else $error("line end without field end on an accepted line");

    // A rejected line carries no byte and always ends the line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_line_status == STATUS_EMPTY) |-> m_line_end && !m_out_has_byte)
        else $error("empty line status on a malformed result");

    // A result that is not the last of its run is the bare field end before
    // the final empty field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_field_end && !m_line_end && !m_out_has_byte)
        else $error("leading result of a pair is malformed");

    // The second result of a pair follows its first without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run && m_line_end)
        else $error("second result of a pair did not follow");

endmodule
